### sv/md4_pkg.sv
// md4_pkg: shared types, constants and step tables for the md4 hash engine
// no dependencies; used by md4_msg_buf, md4_round and md4_hash_engine_unit
`default_nettype none

package md4_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] K_ROUND2 = 32'h5A827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'h38;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LAST_STEP = 6'd47;

  localparam logic [1:0] RND_F = 2'd0;
  localparam logic [1:0] RND_G = 2'd1;
  localparam logic [1:0] RND_H = 2'd2;

  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } md4_wr_t;

  // message word index for a step
  function automatic logic [3:0] msg_idx(input logic [5:0] step);
    logic [3:0] k;
    k = step[3:0];
    case (step[5:4])
      RND_F:   msg_idx = k;
      RND_G:   msg_idx = {k[1:0], k[3:2]};
      default: msg_idx = {k[0], k[1], k[2], k[3]};
    endcase
  endfunction

  // left rotate amount for a step
  function automatic logic [4:0] rot_amt(input logic [5:0] step);
    logic [1:0] j;
    j = step[1:0];
    case (step[5:4])
      RND_F: begin
        case (j)
          2'd0:    rot_amt = 5'd3;
          2'd1:    rot_amt = 5'd7;
          2'd2:    rot_amt = 5'd11;
          default: rot_amt = 5'd19;
        endcase
      end
      RND_G: begin
        case (j)
          2'd0:    rot_amt = 5'd3;
          2'd1:    rot_amt = 5'd5;
          2'd2:    rot_amt = 5'd9;
          default: rot_amt = 5'd13;
        endcase
      end
      default: begin
        case (j)
          2'd0:    rot_amt = 5'd3;
          2'd1:    rot_amt = 5'd9;
          2'd2:    rot_amt = 5'd11;
          default: rot_amt = 5'd15;
        endcase
      end
    endcase
  endfunction

endpackage

`default_nettype wire

### sv/md4_msg_buf.sv
// md4_msg_buf: 64-byte block buffer held as sixteen little-endian words
// byte-wide writes, one word read per cycle; uses md4_pkg
`default_nettype none

module md4_msg_buf (
  input  wire logic             clk,
  input  wire md4_pkg::md4_wr_t wr,
  input  wire logic [3:0]       rd_idx,
  output logic [31:0]           rd_word
);

  logic [31:0] words [16];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      words[wr.addr[5:2]][{wr.addr[1:0], 3'b000} +: 8] <= wr.data;
    end
  end

  assign rd_word = words[rd_idx];

endmodule

`default_nettype wire

### sv/md4_round.sv
// md4_round: one md4 step, shared across all 48 steps of a compression
// uses md4_pkg for round constants and rotate table
`default_nettype none

module md4_round (
  input  wire logic [5:0]  step,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] c,
  input  wire logic [31:0] d,
  input  wire logic [31:0] m,
  output logic [31:0]      a_new
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] sum;
  logic [63:0] rot;

  always_comb begin
    case (step[5:4])
      md4_pkg::RND_F: begin
        f = d ^ (b & (c ^ d));
        k = 32'h0;
      end
      md4_pkg::RND_G: begin
        f = (b & c) | (d & (b | c));
        k = md4_pkg::K_ROUND2;
      end
      default: begin
        f = b ^ c ^ d;
        k = md4_pkg::K_ROUND3;
      end
    endcase
    sum = a + f + m + k;
    rot = {sum, sum} << md4_pkg::rot_amt(step);
    a_new = rot[63:32];
  end

endmodule

`default_nettype wire

### sv/md4_hash_engine_unit.sv
// md4_hash_engine_unit: md4 digest engine, top level with byte intake and sequencer
// depends on md4_pkg, md4_msg_buf and md4_round
//
// message channel (msg_valid / msg_stall, kind, data_byte): one byte per
// transfer, or a finish item when kind is 1. bytes go in one per cycle while
// the block buffer fills. the 64th byte of a block starts a compression that
// runs one step per cycle through the shared step unit: 48 steps and then a
// feed-forward step into the chaining value, with msg_stall high throughout.
// a finish item writes the 0x80 marker and then the padding and length one
// byte per cycle until the buffer is full, then compresses; if the marker
// leaves no room for the length, a second block of 64 padding and length
// bytes and another compression follow.
// digest channel (dig_valid / dig_stall, digest_word, last_word): four
// transfers, A first, last_word high on D. while dig_stall is high the word
// holds and no new message byte is taken. after the fourth transfer the
// chaining value, fill, length and flags are re-initialised. rst is synchronous
// and returns the block to the empty-message state with no digest pending.
`default_nettype none

module md4_hash_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        msg_valid,
  output logic             msg_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  data_byte,
  output logic             dig_valid,
  input  wire logic        dig_stall,
  output logic [31:0]      digest_word,
  output logic             last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_FF   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [5:0]  fill;
  logic [63:0] bit_length;
  logic        finishing;
  logic        len_ok;
  logic [5:0]  step;
  logic [1:0]  out_idx;
  logic [31:0] chain [4];
  logic [31:0] wa;
  logic [31:0] wb;
  logic [31:0] wc;
  logic [31:0] wd;

  logic             msg_fire;
  logic             dig_fire;
  logic             start_comp;
  md4_pkg::md4_wr_t wr;
  logic [31:0]      m_word;
  logic [31:0]      a_new;

  assign msg_stall = (state != S_IDLE);
  assign msg_fire  = msg_valid && (state == S_IDLE);
  assign dig_valid = (state == S_OUT);
  assign dig_fire  = dig_valid && !dig_stall;
  assign digest_word = chain[out_idx];
  assign last_word   = (out_idx == 2'd3);

  // buffer write: message byte, marker, zero pad or length byte
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = fill;
    wr.data = data_byte;
    if (msg_fire) begin
      wr.en   = 1'b1;
      wr.data = kind ? md4_pkg::PAD_MARK : data_byte;
    end else if (state == S_PAD) begin
      wr.en   = 1'b1;
      wr.data = (len_ok && fill >= md4_pkg::LEN_POS) ?
                bit_length[{fill[2:0], 3'b000} +: 8] : 8'h00;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (msg_fire) begin
          if (fill == md4_pkg::LAST_BYTE) begin
            state_next = S_COMP;
          end else if (kind) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (fill == md4_pkg::LAST_BYTE) begin
          state_next = S_COMP;
        end
      end
      S_COMP: begin
        if (step == md4_pkg::LAST_STEP) begin
          state_next = S_FF;
        end
      end
      S_FF: begin
        if (!finishing) begin
          state_next = S_IDLE;
        end else if (len_ok) begin
          state_next = S_OUT;
        end else begin
          state_next = S_PAD;
        end
      end
      S_OUT: begin
        if (dig_fire && out_idx == 2'd3) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign start_comp = (state != S_COMP) && (state_next == S_COMP);

  md4_msg_buf u_buf (
    .clk     (clk),
    .wr      (wr),
    .rd_idx  (md4_pkg::msg_idx(step)),
    .rd_word (m_word)
  );

  md4_round u_round (
    .step  (step),
    .a     (wa),
    .b     (wb),
    .c     (wc),
    .d     (wd),
    .m     (m_word),
    .a_new (a_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      bit_length <= '0;
      finishing  <= 1'b0;
      len_ok     <= 1'b0;
      step       <= '0;
      out_idx    <= '0;
      chain[0]   <= md4_pkg::IV_A;
      chain[1]   <= md4_pkg::IV_B;
      chain[2]   <= md4_pkg::IV_C;
      chain[3]   <= md4_pkg::IV_D;
    end else begin
      state <= state_next;
      if (msg_fire) begin
        fill <= fill + 6'd1;
        if (kind) begin
          finishing <= 1'b1;
          len_ok    <= (fill < md4_pkg::LEN_POS);
        end else begin
          bit_length <= bit_length + 64'd8;
        end
      end
      if (state == S_PAD) begin
        fill <= fill + 6'd1;
      end
      if (start_comp) begin
        step <= '0;
      end else if (state == S_COMP) begin
        step <= step + 6'd1;
      end
      if (state == S_FF) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
        if (finishing && !len_ok) begin
          len_ok <= 1'b1;
        end
      end
      if (dig_fire) begin
        out_idx <= out_idx + 2'd1;
        if (out_idx == 2'd3) begin
          chain[0]   <= md4_pkg::IV_A;
          chain[1]   <= md4_pkg::IV_B;
          chain[2]   <= md4_pkg::IV_C;
          chain[3]   <= md4_pkg::IV_D;
          fill       <= '0;
          bit_length <= '0;
          finishing  <= 1'b0;
          len_ok     <= 1'b0;
        end
      end
    end
  end

  // working words rotate roles each step: a, d, c, b update order
  always_ff @(posedge clk) begin
    if (start_comp) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
    end else if (state == S_COMP) begin
      wa <= wd;
      wb <= a_new;
      wc <= wb;
      wd <= wc;
    end
  end

endmodule

`default_nettype wire
